// ----- sv/strmq_pkg.sv -----
`default_nettype none
package strmq_pkg;
	localparam int STRMQ_DEPTH      = 1024;
	localparam int STRMQ_LEVELS     = 11;
	localparam int STRMQ_VALUE_BITS = 16;

	// widths fixed by the port fields
	localparam int VALUE_W = 16;
	localparam int RANGE_W = 10;
	localparam int LEN_W   = RANGE_W + 1;
	localparam int LOG_W   = $clog2(LEN_W);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;
endpackage
`default_nettype wire

// ----- sv/sparse_table_range_minimum.sv -----
// A query's result passes the request, table-read and output registers; a load gives none.
// Throughput: one load or query per cycle while busy is low; results cannot be stalled.
// The load marked last raises busy for the build: each level k takes a set-up state, one read
// pair per entry through the two-read-port table memory and a drain, then a final level check.
// Reset (arst_n low, asynchronous) empties the table and clears the built flag; the
// table memory itself is not cleared and needs no clearing pass.
`default_nettype none
module sparse_table_range_minimum
	import strmq_pkg::*;
#(
	parameter int DEPTH      = STRMQ_DEPTH,
	parameter int LEVELS     = STRMQ_LEVELS,
	parameter int VALUE_BITS = STRMQ_VALUE_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               operation,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               last,
	input  wire logic [RANGE_W-1:0] range_low,
	input  wire logic [RANGE_W-1:0] range_high,
	output logic                    done,
	output logic      [VALUE_W-1:0] minimum,
	output logic                    range_error
);
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int LVL_W  = $clog2(LEVELS);
	localparam int K_W    = $clog2(LEVELS + 1);
	localparam int SPAN_W = ((LEVELS > CNT_W) ? LEVELS : CNT_W) + 1;
	localparam int ADDR_W = LVL_W + IDX_W;
	localparam int WORDS  = LEVELS * (2 ** IDX_W);
	localparam int CMP_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// floor(log2(len)) over the narrow query length
	function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] len);
		logic [LOG_W-1:0] r;
		r = '0;
		for (int b = 0; b < LEN_W; b++) begin
			if (len[b]) begin
				r = LOG_W'(b);
			end
		end
		return r;
	endfunction

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic              ready_q;
	logic [K_W-1:0]    k_q;
	logic [IDX_W-1:0]  i_q;

	// build write pipeline
	logic              bwr_s1;
	logic [ADDR_W-1:0] bwr_addr_s1;

	// query pipeline
	logic              q_valid_s1, q_valid_s2;
	logic              q_ok_s1, q_ok_s2;
	logic [LOG_W-1:0]  q_k_s1;
	logic [RANGE_W-1:0] q_lo_s1, q_hi_s1;

	logic              accept;
	logic [CNT_W-1:0]  cnt_eff;
	logic              load_fits;
	logic [CNT_W-1:0]  cnt_next;
	logic [LEN_W-1:0]  q_len;
	logic [LOG_W-1:0]  q_k;
	logic              q_ok;
	logic [SPAN_W-1:0] span, half;
	logic              span_fits;
	logic              run_last;
	logic [LEN_W-1:0]  q_pow_s1;
	logic [LEN_W-1:0]  q_start_b;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
	logic [VALUE_BITS-1:0] ram_wdata, rdata_a, rdata_b, rd_min;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// a load after a finished build opens a new sequence
	assign cnt_eff   = ready_q ? '0 : count_q;
	assign load_fits = (cnt_eff < CNT_W'(DEPTH));
	assign cnt_next  = load_fits ? cnt_eff + 1'b1 : cnt_eff;

	// query checks at acceptance
	assign q_len = LEN_W'(range_high) - LEN_W'(range_low) + 1'b1;
	assign q_k   = floor_log2(q_len);
	assign q_ok  = ready_q && (range_low <= range_high)
		&& (CMP_W'(range_high) < CMP_W'(count_q))
		&& (32'(q_k) < LEVELS);

	// build control
	assign span      = SPAN_W'(1) << k_q;
	assign half      = span >> 1;
	assign span_fits = (32'(k_q) < LEVELS) && (span <= SPAN_W'(count_q));
	assign run_last  = (SPAN_W'(i_q) + span == SPAN_W'(count_q));

	// second read index of a query: high - 2^k + 1
	assign q_pow_s1  = LEN_W'(1) << q_k_s1;
	assign q_start_b = LEN_W'(q_hi_s1) - q_pow_s1 + 1'b1;

	assign rd_min = (rdata_a < rdata_b) ? rdata_a : rdata_b;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {LVL_W'(0), cnt_eff[IDX_W-1:0]};
		ram_wdata = VALUE_BITS'(value);
		if (bwr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = bwr_addr_s1;
			ram_wdata = rd_min;
		end else if (accept && operation == OP_LOAD && load_fits) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		if (state_q == ST_RUN) begin
			ram_raddr_a = {LVL_W'(k_q - 1'b1), i_q};
			ram_raddr_b = {LVL_W'(k_q - 1'b1), IDX_W'(SPAN_W'(i_q) + half)};
		end else begin
			ram_raddr_a = {LVL_W'(q_k_s1), IDX_W'(q_lo_s1)};
			ram_raddr_b = {LVL_W'(q_k_s1), IDX_W'(q_start_b)};
		end
	end

	strmq_ram #(
		.DATA_W(VALUE_BITS),
		.ADDR_W(ADDR_W),
		.WORDS (WORDS)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(ram_raddr_a),
		.raddr_b(ram_raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// query payload and build write address, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			q_k_s1  <= q_k;
			q_lo_s1 <= range_low;
			q_hi_s1 <= range_high;
		end
		bwr_addr_s1 <= {LVL_W'(k_q), i_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ready_q     <= 1'b0;
			k_q         <= '0;
			i_q         <= '0;
			bwr_s1      <= 1'b0;
			q_valid_s1  <= 1'b0;
			q_valid_s2  <= 1'b0;
			q_ok_s1     <= 1'b0;
			q_ok_s2     <= 1'b0;
			done        <= 1'b0;
			minimum     <= '0;
			range_error <= 1'b0;
		end else begin
			q_valid_s1  <= accept && (operation == OP_QUERY);
			q_ok_s1     <= q_ok;
			q_valid_s2  <= q_valid_s1;
			q_ok_s2     <= q_ok_s1;
			done        <= q_valid_s2;
			minimum     <= q_ok_s2 ? VALUE_W'(rd_min) : '0;
			range_error <= !q_ok_s2;
			bwr_s1      <= (state_q == ST_RUN);

			case (state_q)
				ST_IDLE: begin
					if (accept && operation == OP_LOAD) begin
						count_q <= cnt_next;
						ready_q <= 1'b0;
						if (last) begin
							k_q     <= K_W'(1);
							state_q <= ST_LEVEL;
						end
					end
				end
				ST_LEVEL: begin
					i_q <= '0;
					if (span_fits) begin
						state_q <= ST_RUN;
					end else begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (run_last) begin
						state_q <= ST_DRAIN;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// last write of the level lands now; next level reads after it
					k_q     <= k_q + 1'b1;
					state_q <= ST_LEVEL;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- sv/strmq_ram.sv -----
`default_nettype none
module strmq_ram #(
	parameter int DATA_W = 16,
	parameter int ADDR_W = 14,
	parameter int WORDS  = 11264
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [DATA_W-1:0] rdata_a,
	output logic      [DATA_W-1:0] rdata_b
);
	logic [DATA_W-1:0] mem [0:WORDS-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

// ----- tb/sv/sparse_table_range_minimum_tb.sv -----
`default_nettype none
module sparse_table_range_minimum_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import strmq_pkg::*;

	// Run length guard. The slowest correct run stays well under the limit:
	// about 400 requests at 30% idle, rebuilds of at most 200 elements.
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned RANDOM_ITEMS = 360;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                operation;
	logic [VALUE_W-1:0]  value;
	logic                last;
	logic [RANGE_W-1:0]  range_low;
	logic [RANGE_W-1:0]  range_high;
	logic                done;
	logic [VALUE_W-1:0]  minimum;
	logic                range_error;

	sparse_table_range_minimum uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.value      (value),
		.last       (last),
		.range_low  (range_low),
		.range_high (range_high),
		.done       (done),
		.minimum    (minimum),
		.range_error(range_error)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Predicted block state: the sparse table, how many elements the
	// current sequence holds, and whether the table has been built.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [VALUE_W-1:0] minimum;
		logic               range_error;
	} range_result_t;

	logic [VALUE_W-1:0] min_levels [STRMQ_LEVELS][STRMQ_DEPTH];
	int unsigned        elem_count = 0;
	bit                 built = 1'b0;

	// Results of accepted queries, oldest first.
	range_result_t pending_minima [$];

	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit          steady = 1'b0;   // suppresses sender idling

	// Level k, entry i = min of level k-1 entries i and i + 2^(k-1).
	// Only entries fully covered by the loaded elements are written.
	function automatic void build_levels();
		int unsigned half;
		logic [VALUE_W-1:0] a;
		logic [VALUE_W-1:0] b;
		for (int k = 1; k < STRMQ_LEVELS && (1 << k) <= elem_count; k++) begin
			half = 1 << (k - 1);
			for (int i = 0; i + (1 << k) <= elem_count; i++) begin
				a = min_levels[k-1][i];
				b = min_levels[k-1][i + half];
				min_levels[k][i] = (a < b) ? a : b;
			end
		end
		built = 1'b1;
	endfunction

	function automatic void apply_load(input logic [VALUE_W-1:0] v, input logic mark);
		// a load after a build opens a fresh sequence
		if (built) begin
			built = 1'b0;
			elem_count = 0;
		end
		// past DEPTH the value is dropped, but a last mark still builds
		if (elem_count < STRMQ_DEPTH) begin
			min_levels[0][elem_count] = v;
			elem_count++;
		end
		if (mark) begin
			build_levels();
		end
	endfunction

	function automatic range_result_t range_lookup(input logic [RANGE_W-1:0] lo,
			input logic [RANGE_W-1:0] hi);
		range_result_t r;
		int unsigned span;
		int unsigned lvl;
		logic [VALUE_W-1:0] a;
		logic [VALUE_W-1:0] b;
		r.minimum = '0;
		r.range_error = 1'b1;
		// not built, reversed, or past the data: error with zero minimum
		if (built && lo <= hi && hi < elem_count) begin
			span = int'(hi) - int'(lo) + 1;
			lvl = 0;
			while (lvl < 31 && (1 << (lvl + 1)) <= span) begin
				lvl++;
			end
			// two overlapping windows of 2^lvl cover [lo, hi]
			if (lvl < STRMQ_LEVELS) begin
				a = min_levels[lvl][lo];
				b = min_levels[lvl][int'(hi) - (1 << lvl) + 1];
				r.minimum = (a < b) ? a : b;
				r.range_error = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("tb: mismatch at cycle %0d: %s: want %0h got %0h",
			cycle_count, what, want, got);
		fail_count++;
	endtask

	// ------------------------------------------------------------------
	// Request driver. Fields change only at rising edges, with one
	// nonblocking assignment per signal per step; start is lowered only
	// when an idle cycle is inserted, never between back-to-back requests.
	// Prediction happens at the edge that accepts the request.
	// ------------------------------------------------------------------
	task automatic issue_request(input logic op, input logic [VALUE_W-1:0] v,
			input logic mark, input logic [RANGE_W-1:0] lo,
			input logic [RANGE_W-1:0] hi, input bit typed,
			input logic [VALUE_W-1:0] typed_min, input logic typed_err);
		range_result_t r;
		while (!steady && $urandom_range(99, 0) < 30) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		operation  <= op;
		value      <= v;
		last       <= mark;
		range_low  <= lo;
		range_high <= hi;
		// accepted at the first edge with busy low
		do begin
			@(posedge clk);
		end while (busy);
		if (op == OP_LOAD) begin
			apply_load(v, mark);
		end else begin
			if (typed) begin
				r.minimum = typed_min;
				r.range_error = typed_err;
			end else begin
				r = range_lookup(lo, hi);
			end
			pending_minima = {pending_minima, r};
		end
	endtask

	// Query with random unused fields. Valid ranges favor exact powers of
	// two now and then, which land on a single table entry.
	task automatic issue_random_query(input bit want_valid);
		logic [RANGE_W-1:0] lo;
		logic [RANGE_W-1:0] hi;
		int unsigned span;
		lo = RANGE_W'($urandom);
		hi = RANGE_W'($urandom);
		if (want_valid && built && elem_count > 0) begin
			span = 1 << $urandom_range(10, 0);
			if ($urandom_range(3, 0) == 0 && span <= elem_count) begin
				lo = RANGE_W'($urandom_range(elem_count - span, 0));
				hi = RANGE_W'(int'(lo) + span - 1);
			end else begin
				lo = RANGE_W'($urandom_range(elem_count - 1, 0));
				hi = RANGE_W'($urandom_range(elem_count - 1, lo));
			end
		end
		issue_request(OP_QUERY, VALUE_W'($urandom), 1'($urandom), lo, hi,
			1'b0, '0, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Result checker: every done pulse is compared with the oldest
	// pending query result.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		range_result_t want;
		if (arst_n && done) begin
			if (pending_minima.size() == 0) begin
				report_mismatch("result with no query pending", 0, 32'(minimum));
			end else begin
				want = pending_minima.pop_front();
				if (minimum !== want.minimum) begin
					report_mismatch("minimum", 32'(want.minimum), 32'(minimum));
				end
				if (range_error !== want.range_error) begin
					report_mismatch("range_error", 32'(want.range_error),
						32'(range_error));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed requests. Expected results are typed in for the obvious
	// cases (errors, single elements, a full-range minimum of zero);
	// the rest go through the predictor.
	// ------------------------------------------------------------------
	typedef struct {
		logic               op;
		logic [VALUE_W-1:0] v;
		logic               mark;
		logic [RANGE_W-1:0] lo;
		logic [RANGE_W-1:0] hi;
		bit                 typed;
		logic [VALUE_W-1:0] want_min;
		logic               want_err;
	} stim_row_t;

	stim_row_t directed_rows [0:20] = '{
		// query straight out of reset: nothing built
		'{OP_QUERY, 16'h0000, 1'b0, 10'd0,    10'd0,    1'b1, 16'h0000, 1'b1},
		// five loads, extremes of value, build on the last
		'{OP_LOAD,  16'hFFFF, 1'b0, 10'd0,    10'd0,    1'b0, 16'h0000, 1'b0},
		'{OP_LOAD,  16'h0000, 1'b0, 10'd1023, 10'd1023, 1'b0, 16'h0000, 1'b0},
		'{OP_LOAD,  16'h8000, 1'b0, 10'd0,    10'd1023, 1'b0, 16'h0000, 1'b0},
		'{OP_LOAD,  16'h1234, 1'b0, 10'd1023, 10'd0,    1'b0, 16'h0000, 1'b0},
		'{OP_LOAD,  16'h5555, 1'b1, 10'd0,    10'd0,    1'b0, 16'h0000, 1'b0},
		// single elements, the whole set and a partial range
		'{OP_QUERY, 16'h0000, 1'b0, 10'd0,    10'd0,    1'b1, 16'hFFFF, 1'b0},
		'{OP_QUERY, 16'hFFFF, 1'b1, 10'd1,    10'd1,    1'b1, 16'h0000, 1'b0},
		'{OP_QUERY, 16'h0000, 1'b0, 10'd0,    10'd4,    1'b1, 16'h0000, 1'b0},
		'{OP_QUERY, 16'h0000, 1'b0, 10'd2,    10'd4,    1'b0, 16'h0000, 1'b0},
		// reversed range, one past the data, far past the data
		'{OP_QUERY, 16'h0000, 1'b0, 10'd3,    10'd2,    1'b1, 16'h0000, 1'b1},
		'{OP_QUERY, 16'h0000, 1'b0, 10'd0,    10'd5,    1'b1, 16'h0000, 1'b1},
		'{OP_QUERY, 16'h0000, 1'b0, 10'd1023, 10'd1023, 1'b1, 16'h0000, 1'b1},
		'{OP_QUERY, 16'h0000, 1'b0, 10'd0,    10'd1023, 1'b1, 16'h0000, 1'b1},
		// load after a build restarts; table is unbuilt until the next last
		'{OP_LOAD,  16'h00FF, 1'b0, 10'd1023, 10'd1023, 1'b0, 16'h0000, 1'b0},
		'{OP_QUERY, 16'hFFFF, 1'b1, 10'd0,    10'd0,    1'b1, 16'h0000, 1'b1},
		'{OP_LOAD,  16'hAAAA, 1'b1, 10'd0,    10'd0,    1'b0, 16'h0000, 1'b0},
		'{OP_QUERY, 16'h0000, 1'b0, 10'd0,    10'd1,    1'b0, 16'h0000, 1'b0},
		'{OP_QUERY, 16'h0000, 1'b0, 10'd1,    10'd1,    1'b0, 16'h0000, 1'b0},
		// one-element sequence
		'{OP_LOAD,  16'h0007, 1'b1, 10'd0,    10'd0,    1'b0, 16'h0000, 1'b0},
		'{OP_QUERY, 16'h0000, 1'b0, 10'd0,    10'd0,    1'b0, 16'h0000, 1'b0}
	};

	initial begin
		int unsigned items;
		int unsigned seq_len;
		int unsigned pick;
		int unsigned n_queries;
		int unsigned wait_cycles;
		bit          narrow;
		bit          drop_last;
		logic [VALUE_W-1:0] v;

		arst_n     <= 1'b0;
		start      <= 1'b0;
		operation  <= OP_LOAD;
		value      <= '0;
		last       <= 1'b0;
		range_low  <= '0;
		range_high <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			issue_request(directed_rows[r].op, directed_rows[r].v, directed_rows[r].mark,
				directed_rows[r].lo, directed_rows[r].hi, directed_rows[r].typed,
				directed_rows[r].want_min, directed_rows[r].want_err);
		end

		// Random part: mostly well-formed load sequences ending in last,
		// followed by a burst of queries. Noise: queries dropped in mid-load,
		// sequences missing their last mark, out-of-range queries.
		items = 0;
		while (items < RANDOM_ITEMS) begin
			// one long stretch with the sender never idling
			steady = (items >= 150 && items < 260);
			pick = $urandom_range(99, 0);
			if (pick < 70) begin
				seq_len = $urandom_range(16, 1);
			end else if (pick < 92) begin
				seq_len = $urandom_range(64, 17);
			end else begin
				seq_len = $urandom_range(200, 65);
			end
			// narrow values make ties and repeated minima likely
			narrow = ($urandom_range(3, 0) == 0);
			drop_last = ($urandom_range(9, 0) == 0);
			for (int i = 0; i < seq_len; i++) begin
				if ($urandom_range(19, 0) == 0) begin
					issue_random_query(1'b1);
					items++;
				end
				v = narrow ? VALUE_W'($urandom_range(7, 0)) : VALUE_W'($urandom);
				issue_request(OP_LOAD, v, (i == seq_len - 1) && !drop_last,
					RANGE_W'($urandom), RANGE_W'($urandom), 1'b0, '0, 1'b0);
				items++;
			end
			n_queries = $urandom_range(20, 4);
			for (int q = 0; q < n_queries; q++) begin
				issue_random_query($urandom_range(99, 0) < 80);
				items++;
			end
		end
		steady = 1'b0;

		// Drain: wait out the pending queries, then wait on for strays.
		start <= 1'b0;
		wait_cycles = 0;
		while (pending_minima.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (pending_minima.size() != 0) begin
			report_mismatch("query results never arrived", pending_minima.size(), 0);
		end

		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire
